[rtl/stk_pkg.sv]
// Shared action, status and command definitions for the stack with search.
package stk_pkg;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_PEEK   = 3'd2;
  localparam logic [2:0] ACT_CHANGE = 3'd3;
  localparam logic [2:0] ACT_SEARCH = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef logic [2:0] op_t;

  localparam op_t OP_NOP    = 3'd0;
  localparam op_t OP_PUSH   = 3'd1;
  localparam op_t OP_POP    = 3'd2;
  localparam op_t OP_PEEK   = 3'd3;
  localparam op_t OP_CHANGE = 3'd4;
  localparam op_t OP_SEARCH = 3'd5;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

endpackage

[rtl/stk_ifs.sv]
// Request and response channel interfaces of the stack with search.
interface stk_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface stk_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [6:0]         found_index;
  logic [7:0]         entry_count;

  modport source (output valid, status, top_value, found_index, entry_count, input ready);
  modport sink   (input valid, status, top_value, found_index, entry_count, output ready);
endinterface

[rtl/stk_front.sv]
// Front end: takes request words, decodes the action and queues commands.
module stk_front (
  input  logic            clk,
  input  logic            rst,
  stk_req_if.sink         req,
  output logic            cmd_valid,
  output stk_pkg::cmd_t   cmd,
  input  logic            cmd_take
);

  stk_pkg::cmd_t slot [2];
  stk_pkg::cmd_t cmd_in;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          push;
  logic          pop;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = cmd_valid && cmd_take;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_comb begin
    cmd_in.value = req.value;
    unique case (req.action)
      stk_pkg::ACT_PUSH:   cmd_in.op = stk_pkg::OP_PUSH;
      stk_pkg::ACT_POP:    cmd_in.op = stk_pkg::OP_POP;
      stk_pkg::ACT_PEEK:   cmd_in.op = stk_pkg::OP_PEEK;
      stk_pkg::ACT_CHANGE: cmd_in.op = stk_pkg::OP_CHANGE;
      stk_pkg::ACT_SEARCH: cmd_in.op = stk_pkg::OP_SEARCH;
      default:             cmd_in.op = stk_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/stk_back.sv]
// Back end: stack memory, fill count, search sequencer and response register.
module stk_back #(
  parameter int DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  stk_pkg::cmd_t   cmd,
  output logic            cmd_take,
  stk_rsp_if.source       rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PEEK   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;
  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [AW-1:0] cur;
  logic [AW-1:0] cur_next;
  logic [31:0]   key;
  logic [31:0]   key_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] top_addr;
  logic          slot_free;
  logic          empty;
  logic          full;

  logic          res_load;
  logic [1:0]    res_status;
  logic [31:0]   res_top;
  logic [AW-1:0] res_idx;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [31:0]   out_top;
  logic [6:0]    out_idx;
  logic [7:0]    out_count;

  assign slot_free = !out_valid || rsp.ready;
  assign cmd_take  = (state == S_IDLE) && cmd_valid && slot_free;
  assign empty     = (cnt == '0);
  assign full      = (cnt == FULL);
  assign top_addr  = AW'(cnt - CW'(1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cur_next   = cur;
    key_next   = key;
    mem_we     = 1'b0;
    mem_waddr  = top_addr;
    rd_en      = 1'b0;
    rd_addr    = top_addr;
    res_load   = 1'b0;
    res_status = stk_pkg::ST_OK;
    res_top    = '0;
    res_idx    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.op)
            stk_pkg::OP_PUSH: begin
              res_load = 1'b1;
              if (full) begin
                res_status = stk_pkg::ST_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt);
                cnt_next  = cnt + CW'(1);
              end
            end
            stk_pkg::OP_POP: begin
              res_load = 1'b1;
              if (empty) begin
                res_status = stk_pkg::ST_EMPTY;
              end else begin
                cnt_next = cnt - CW'(1);
              end
            end
            stk_pkg::OP_PEEK: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = stk_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = S_PEEK;
              end
            end
            stk_pkg::OP_CHANGE: begin
              res_load = 1'b1;
              if (empty) begin
                res_status = stk_pkg::ST_EMPTY;
              end else begin
                mem_we = 1'b1;
              end
            end
            stk_pkg::OP_SEARCH: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = stk_pkg::ST_NOTFOUND;
              end else begin
                rd_en      = 1'b1;
                cur_next   = top_addr;
                key_next   = cmd.value;
                state_next = S_SEARCH;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res_top    = rd_data;
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (rd_data == key) begin
          if (slot_free) begin
            res_load   = 1'b1;
            res_idx    = cur;
            state_next = S_IDLE;
          end
        end else if (cur == '0) begin
          if (slot_free) begin
            res_load   = 1'b1;
            res_status = stk_pkg::ST_NOTFOUND;
            state_next = S_IDLE;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = cur - AW'(1);
          cur_next = cur - AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    key <= key_next;
    if (res_load) begin
      out_status <= res_status;
      out_top    <= res_top;
      out_idx    <= 7'(res_idx);
      out_count  <= 8'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.top_value   = out_top;
  assign rsp.found_index = out_idx;
  assign rsp.entry_count = out_count;

endmodule

[rtl/stack_with_search.sv]
// Top level of the LIFO stack with linear search.
// Push, pop and change pass through the command queue and the response register; peek
// adds the registered memory read; search walks one entry per cycle from the top down
// through the single read port of the stack memory. Throughput: one word per cycle
// for push, pop and change unless responses stall; a two-entry command queue
// decouples request intake from execution. Reset empties the stack and drops all words.
module stack_with_search #(
  parameter int DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  stk_req_if.sink   req,
  stk_rsp_if.source rsp
);

  logic          cmd_valid;
  logic          cmd_take;
  stk_pkg::cmd_t cmd;

  stk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  stk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .rsp       (rsp)
  );

endmodule

[rtl/stk_check.sv]
// Port-level checks on the response channel of the stack with search.
module stk_check #(
  parameter int DEPTH = 128
) (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [31:0] top_value,
  input logic [6:0]  found_index,
  input logic [7:0]  entry_count
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(top_value)
      && $stable(found_index) && $stable(entry_count))
    else $error("response word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == stk_pkg::ST_OVERFLOW |-> entry_count == 8'(DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_data_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (top_value != '0 || found_index != '0) |-> status == stk_pkg::ST_OK)
    else $error("data returned with an error status");

endmodule

bind stack_with_search stk_check #(
  .DEPTH (DEPTH)
) u_stk_check (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .top_value   (rsp.top_value),
  .found_index (rsp.found_index),
  .entry_count (rsp.entry_count)
);
